[rtl/lcg48_pkg.sv]
// shared types, codes and constants for the 48-bit lcg random generator
package lcg48_pkg;

    localparam int SEED_W = 48;
    localparam int CHUNK_W = 16;
    localparam int BOUND_W = 31;
    localparam int TRIES_W = 11;

    localparam logic [SEED_W-1:0] MULT_DEFAULT = 48'd25214903917;
    localparam logic [SEED_W-1:0] LCG_INC = 48'hB;
    localparam logic [TRIES_W-1:0] MAX_TRIES = 11'd1024;

    localparam logic [2:0] KIND_SEED = 3'd0;
    localparam logic [2:0] KIND_INT32 = 3'd1;
    localparam logic [2:0] KIND_INT64 = 3'd2;
    localparam logic [2:0] KIND_BOOL = 3'd3;
    localparam logic [2:0] KIND_BOUNDED = 3'd4;
    localparam logic [2:0] KIND_FLOAT = 3'd5;
    localparam logic [2:0] KIND_DOUBLE = 3'd6;

    typedef struct packed {
        logic [2:0] kind;
        logic signed [63:0] seed_value;
        logic signed [31:0] bound;
    } req_t;

    typedef struct packed {
        logic [63:0] random_bits;
        logic bad_bound;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_INC,
        ST_POST,
        ST_DIV,
        ST_CHECK,
        ST_OUT
    } state_t;

endpackage

[rtl/lcg48_random_generator_core.sv]
// top level of the 48-bit lcg random generator
//
// request channel: req_valid / req_stall / req_data (kind, seed_value, bound)
// response channel: rsp_valid / rsp_stall / rsp_data (random_bits, bad_bound)
// config channel: cfg_valid / cfg_ready / cfg_data writes the 48-bit multiplier
// one request at a time: req_stall is high from the transfer until the response is loaded
// each seed step runs on one shared 48-bit adder: three 48x16 partial product
// steps, one step adding the increment and one taking the bits
// int32, boolean and float take one seed step before the response register; int64
// and double take two seed steps; bounded power of two takes one seed step
// other bounded requests: each draw adds a 31-bit restoring remainder on the
// same adder plus the rejection check, repeated while a draw is rejected (up to
// MAX_TRIES draws), then the result goes to the response register
// set-seed and the unused kind finish in the transfer cycle with no response;
// a bad bound goes straight to the output state and leaves the seed alone
// the response register holds its transfer while rsp_stall is high, and a new
// request is still taken then; the block waits to load its next result
// reset clears the seed to zero, restores the default multiplier and empties
// the response register
module lcg48_random_generator_core (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  lcg48_pkg::req_t req_data,
    output logic rsp_valid,
    input  logic rsp_stall,
    output lcg48_pkg::rsp_t rsp_data,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [lcg48_pkg::SEED_W-1:0] cfg_data
);
    import lcg48_pkg::*;

    state_t state_reg, state_next;
    logic [SEED_W-1:0] seed_reg, seed_next;
    logic [SEED_W-1:0] mult_reg, mult_next;
    logic [SEED_W-1:0] acc_reg, acc_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [2:0] kind_reg, kind_next;
    logic [BOUND_W-1:0] bound_reg, bound_next;
    logic [BOUND_W-1:0] draw_reg, draw_next;
    logic [BOUND_W-1:0] rem_reg, rem_next;
    logic [4:0] bit_reg, bit_next;
    logic [TRIES_W-1:0] tries_reg, tries_next;
    logic idx_reg, idx_next;
    logic [31:0] hi_reg, hi_next;
    logic [63:0] result_reg, result_next;
    logic bad_reg, bad_next;
    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_data_reg, rsp_data_next;

    logic [CHUNK_W-1:0] chunk;
    logic [63:0] pp;
    logic [SEED_W-1:0] pp_shift;
    logic [SEED_W-1:0] alu_a, alu_b;
    logic alu_sub;
    logic [SEED_W:0] alu_sum;
    logic [31:0] trial;
    logic [32:0] reject_sum;
    logic req_take;

    function automatic logic [BOUND_W-1:0] pow2_scale(
        input logic [BOUND_W-1:0] n,
        input logic [BOUND_W-1:0] d
    );
        logic [BOUND_W-1:0] res;
        res = '0;
        for (int i = 0; i < BOUND_W; i++)
        begin
            if (n[i])
            begin
                res = d >> (BOUND_W - i);
            end
        end
        return res;
    endfunction

    // 48x16 partial product for the current chunk of the multiplier
    always_comb
    begin
        case (cnt_reg)
            2'd0: chunk = mult_reg[15:0];
            2'd1: chunk = mult_reg[31:16];
            default: chunk = mult_reg[47:32];
        endcase
        pp = 64'(seed_reg) * 64'(chunk);
        case (cnt_reg)
            2'd0: pp_shift = pp[47:0];
            2'd1: pp_shift = {pp[31:0], 16'b0};
            default: pp_shift = {pp[15:0], 32'b0};
        endcase
    end

    assign trial = {rem_reg, draw_reg[bit_reg]};

    // shared adder: multiply accumulate, increment and remainder subtract
    always_comb
    begin
        case (state_reg)
            ST_MUL:
            begin
                alu_a = acc_reg;
                alu_b = pp_shift;
                alu_sub = 1'b0;
            end
            ST_INC:
            begin
                alu_a = acc_reg;
                alu_b = LCG_INC;
                alu_sub = 1'b0;
            end
            ST_DIV:
            begin
                alu_a = 48'(trial);
                alu_b = 48'(bound_reg);
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
                alu_sub = 1'b0;
            end
        endcase
        alu_sum = {1'b0, alu_a} + {1'b0, alu_b ^ {SEED_W{alu_sub}}} + 49'(alu_sub);
    end

    assign reject_sum = 33'(draw_reg) - 33'(rem_reg) + 33'(bound_reg - 31'd1);
    assign req_take = req_valid && !req_stall;

    assign req_stall = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data = rsp_data_reg;

    always_comb
    begin
        state_next = state_reg;
        seed_next = seed_reg;
        mult_next = mult_reg;
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        kind_next = kind_reg;
        bound_next = bound_reg;
        draw_next = draw_reg;
        rem_next = rem_reg;
        bit_next = bit_reg;
        tries_next = tries_reg;
        idx_next = idx_reg;
        hi_next = hi_reg;
        result_next = result_reg;
        bad_next = bad_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next = rsp_data_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            mult_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    kind_next = req_data.kind;
                    bound_next = req_data.bound[BOUND_W-1:0];
                    tries_next = '0;
                    idx_next = 1'b0;
                    bad_next = 1'b0;
                    acc_next = '0;
                    cnt_next = '0;
                    case (req_data.kind)
                        KIND_SEED:
                        begin
                            seed_next = req_data.seed_value[SEED_W-1:0] ^ mult_reg;
                        end
                        KIND_INT32, KIND_INT64, KIND_BOOL, KIND_FLOAT, KIND_DOUBLE:
                        begin
                            state_next = ST_MUL;
                        end
                        KIND_BOUNDED:
                        begin
                            if (req_data.bound[31] || req_data.bound == 32'sd0)
                            begin
                                result_next = '0;
                                bad_next = 1'b1;
                                state_next = ST_OUT;
                            end
                            else
                            begin
                                state_next = ST_MUL;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                acc_next = alu_sum[SEED_W-1:0];
                if (cnt_reg == 2'd2)
                begin
                    state_next = ST_INC;
                end
                else
                begin
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            ST_INC:
            begin
                seed_next = alu_sum[SEED_W-1:0];
                state_next = ST_POST;
            end
            ST_POST:
            begin
                state_next = ST_OUT;
                case (kind_reg)
                    KIND_INT32:
                    begin
                        result_next = 64'(seed_reg[47:16]);
                    end
                    KIND_INT64:
                    begin
                        if (!idx_reg)
                        begin
                            hi_next = seed_reg[47:16];
                            idx_next = 1'b1;
                            acc_next = '0;
                            cnt_next = '0;
                            state_next = ST_MUL;
                        end
                        else
                        begin
                            result_next = {hi_reg, 32'b0}
                                + {{32{seed_reg[47]}}, seed_reg[47:16]};
                        end
                    end
                    KIND_BOOL:
                    begin
                        result_next = 64'(seed_reg[47]);
                    end
                    KIND_FLOAT:
                    begin
                        result_next = 64'(seed_reg[47:24]);
                    end
                    KIND_DOUBLE:
                    begin
                        if (!idx_reg)
                        begin
                            hi_next = 32'(seed_reg[47:22]);
                            idx_next = 1'b1;
                            acc_next = '0;
                            cnt_next = '0;
                            state_next = ST_MUL;
                        end
                        else
                        begin
                            result_next = 64'({hi_reg[25:0], seed_reg[47:21]});
                        end
                    end
                    KIND_BOUNDED:
                    begin
                        tries_next = tries_reg + 11'd1;
                        if ((bound_reg & (bound_reg - 31'd1)) == '0)
                        begin
                            result_next = 64'(pow2_scale(bound_reg, seed_reg[47:17]));
                        end
                        else
                        begin
                            draw_next = seed_reg[47:17];
                            rem_next = '0;
                            bit_next = 5'(BOUND_W - 1);
                            state_next = ST_DIV;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_DIV:
            begin
                // restoring remainder, one draw bit per cycle from the top
                if (alu_sum[SEED_W])
                begin
                    rem_next = alu_sum[BOUND_W-1:0];
                end
                else
                begin
                    rem_next = trial[BOUND_W-1:0];
                end
                if (bit_reg == 5'd0)
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    bit_next = bit_reg - 5'd1;
                end
            end
            ST_CHECK:
            begin
                if ((reject_sum[32:31] != 2'b00) && (tries_reg < MAX_TRIES))
                begin
                    acc_next = '0;
                    cnt_next = '0;
                    state_next = ST_MUL;
                end
                else
                begin
                    result_next = 64'(rem_reg);
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next.random_bits = result_reg;
                    rsp_data_next.bad_bound = bad_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seed_reg <= '0;
            mult_reg <= MULT_DEFAULT;
            cnt_reg <= '0;
            bit_reg <= '0;
            tries_reg <= '0;
            idx_reg <= 1'b0;
            kind_reg <= KIND_SEED;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            seed_reg <= seed_next;
            mult_reg <= mult_next;
            cnt_reg <= cnt_next;
            bit_reg <= bit_next;
            tries_reg <= tries_next;
            idx_reg <= idx_next;
            kind_reg <= kind_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        bound_reg <= bound_next;
        draw_reg <= draw_next;
        rem_reg <= rem_next;
        hi_reg <= hi_next;
        result_reg <= result_next;
        bad_reg <= bad_next;
        rsp_data_reg <= rsp_data_next;
    end

endmodule

[rtl/lcg48_checker.sv]
// port-level checker for the lcg random generator and its bind
module lcg48_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input lcg48_pkg::req_t req_data,
    input logic rsp_valid,
    input logic rsp_stall,
    input lcg48_pkg::rsp_t rsp_data
);
    import lcg48_pkg::*;

    // a stalled response keeps its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("response changed while stalled");

    // a bad bound always comes with a zero result
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.bad_bound |-> rsp_data.random_bits == 64'd0)
        else $error("bad bound with nonzero result");

    // an int32 request keeps the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req_data.kind == KIND_INT32 |=> req_stall)
        else $error("not busy after int32 request");

    // set-seed completes in its own transfer cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req_data.kind == KIND_SEED |=> !req_stall)
        else $error("busy after set-seed request");

endmodule

bind lcg48_random_generator_core lcg48_checker u_lcg48_checker (
    .clk(clk),
    .rst_n(rst_n),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data(req_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data(rsp_data)
);

[dv/tb_top.sv]
// testbench for lcg48_random_generator_core: directed table then random requests under several multipliers
`timescale 1ns / 100ps

module tb_top;
    import lcg48_pkg::*;

    localparam logic [2:0] KIND_UNUSED = 3'd7;
    localparam int N_PHASES = 7;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT = 200000;

    typedef struct {
        req_t req;
        bit   fixed;
        rsp_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req_data;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [SEED_W-1:0] cfg_data;

    logic [SEED_W-1:0] mult_q;
    logic [SEED_W-1:0] lcg_q;
    rsp_t pending_draws[$];
    dir_row_t dir_rows[$];

    int gap_rate;
    int stall_rate;
    int stall_left;
    int quiet_cycles;
    int mismatches;
    int n_sent;
    int n_checked;
    int n_bad_bound;

    logic [SEED_W-1:0] ph_mult[N_PHASES];
    bit ph_tame[N_PHASES];
    int ph_items[N_PHASES];

    lcg48_random_generator_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_data(req_data),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_data(rsp_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] lcg_draw(input int unsigned nbits);
        lcg_q = lcg_q * mult_q + LCG_INC;
        return 32'(lcg_q >> (SEED_W - nbits));
    endfunction

    function automatic logic [63:0] lcg_below(input logic [31:0] n);
        logic [31:0] d;
        logic [31:0] v;
        int unsigned tries;
        tries = 0;
        v = '0;
        if ((n & (n - 32'd1)) == 32'd0)
            return (64'(n) * 64'(lcg_draw(BOUND_W))) >> BOUND_W;
        do
        begin
            d = lcg_draw(BOUND_W);
            v = d % n;
            tries++;
        end
        while ((64'(d) - 64'(v) + 64'(n - 32'd1)) >= 64'h8000_0000 && tries < MAX_TRIES);
        return 64'(v);
    endfunction

    function automatic bit predict_draw(input req_t r, output rsp_t out);
        logic [31:0] hi;
        logic [31:0] lo;
        out = '0;
        case (r.kind)
            KIND_SEED:
            begin
                lcg_q = r.seed_value[SEED_W-1:0] ^ mult_q;
                return 1'b0;
            end
            KIND_INT32: out.random_bits = 64'(lcg_draw(32));
            KIND_INT64:
            begin
                hi = lcg_draw(32);
                lo = lcg_draw(32);
                out.random_bits = {hi, 32'd0} + {{32{lo[31]}}, lo};
            end
            KIND_BOOL: out.random_bits = 64'(lcg_draw(1));
            KIND_BOUNDED:
            begin
                if (r.bound <= 0)
                    out.bad_bound = 1'b1;
                else
                    out.random_bits = lcg_below(r.bound);
            end
            KIND_FLOAT: out.random_bits = 64'(lcg_draw(24));
            KIND_DOUBLE:
            begin
                hi = lcg_draw(26);
                lo = lcg_draw(27);
                out.random_bits = (64'(hi) << 27) + 64'(lo);
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic dir_row_t row(input logic [2:0] kind, input logic [63:0] seed,
                                     input logic [31:0] bnd, input bit fixed,
                                     input logic [63:0] bits, input logic bad);
        dir_row_t d;
        d.req.kind = kind;
        d.req.seed_value = seed;
        d.req.bound = bnd;
        d.fixed = fixed;
        d.want.random_bits = bits;
        d.want.bad_bound = bad;
        return d;
    endfunction

    function automatic logic [31:0] pick_bound(input bit tame);
        case ($urandom_range(7, 0))
            0: return 32'd1 << $urandom_range(30, 0);
            1: return ($urandom_range(1, 0) == 0) ? 32'd0 : ($urandom() | 32'h8000_0000);
            2: return 32'($urandom_range(100, 1));
            3: return tame ? 32'h7FFF_FFFF : 32'h7FFF_FFFF - 32'($urandom_range(255, 0));
            default: return tame ? 32'($urandom_range(65536, 1)) : $urandom();
        endcase
    endfunction

    function automatic req_t pick_req(input bit tame);
        req_t r;
        int sel;
        sel = $urandom_range(99, 0);
        r.seed_value = {$urandom(), $urandom()};
        r.bound = pick_bound(tame);
        if (sel < 8)
            r.kind = KIND_SEED;
        else if (sel < 10)
            r.kind = KIND_UNUSED;
        else if (sel < 40)
            r.kind = KIND_BOUNDED;
        else
            r.kind = 3'($urandom_range(6, 1));
        return r;
    endfunction

    task automatic send_req(input req_t r, input bit use_fixed, input rsp_t fixed_rsp);
        rsp_t guess;
        req_valid <= 1'b1;
        req_data <= r;
        do
            @(posedge clk);
        while (req_stall);
        n_sent++;
        if (predict_draw(r, guess))
            pending_draws.push_back(use_fixed ? fixed_rsp : guess);
        if (gap_rate > 0 && $urandom_range(99, 0) < gap_rate)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(18, 1)) @(posedge clk);
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_draws.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mult(input logic [SEED_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        mult_q = value;
    endtask

    // response side: check against the oldest expectation, then pick the next stall
    always @(posedge clk)
    begin
        rsp_t want;
        if (rsp_valid && !rsp_stall)
        begin
            if (pending_draws.size() == 0)
            begin
                $error("unexpected response: random_bits %h bad_bound %b",
                       rsp_data.random_bits, rsp_data.bad_bound);
                mismatches++;
            end
            else
            begin
                want = pending_draws.pop_front();
                n_checked++;
                if (want.bad_bound)
                    n_bad_bound++;
                if (rsp_data.random_bits !== want.random_bits)
                begin
                    $error("random_bits: expected %h, got %h", want.random_bits,
                           rsp_data.random_bits);
                    mismatches++;
                end
                if (rsp_data.bad_bound !== want.bad_bound)
                begin
                    $error("bad_bound: expected %b, got %b", want.bad_bound,
                           rsp_data.bad_bound);
                    mismatches++;
                end
            end
        end
        if (stall_left > 0)
            stall_left--;
        else if (stall_rate > 0 && $urandom_range(99, 0) < stall_rate)
            stall_left = $urandom_range(18, 1);
        rsp_stall <= (stall_left > 0);
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        rsp_t none;
        req_t r;
        int sent;
        none = '0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        rsp_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        gap_rate = 0;
        stall_rate = 0;
        stall_left = 0;
        quiet_cycles = 0;
        mismatches = 0;
        n_sent = 0;
        n_checked = 0;
        n_bad_bound = 0;
        mult_q = MULT_DEFAULT;
        lcg_q = '0;

        ph_mult = '{MULT_DEFAULT, 48'd0, 48'hFFFF_FFFF_FFFF, 48'd1,
                    {16'($urandom()), $urandom()} | 48'd1, {16'($urandom()), $urandom()},
                    MULT_DEFAULT};
        ph_tame = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
        ph_items = '{180, 80, 80, 60, 140, 80, 160};

        // seed set to the multiplier clears the state, so the next draw comes from 11
        dir_rows = '{
            row(KIND_INT32, 64'd0, 32'd0, 1'b1, 64'd0, 1'b0),
            row(KIND_BOUNDED, 64'd0, 32'd0, 1'b1, 64'd0, 1'b1),
            row(KIND_BOUNDED, 64'd0, 32'hFFFF_FFFF, 1'b1, 64'd0, 1'b1),
            row(KIND_BOUNDED, '1, 32'h8000_0000, 1'b1, 64'd0, 1'b1),
            row(KIND_UNUSED, '1, '1, 1'b0, 64'd0, 1'b0),
            row(KIND_SEED, 64'(MULT_DEFAULT), 32'd0, 1'b0, 64'd0, 1'b0),
            row(KIND_BOOL, 64'd0, 32'd0, 1'b1, 64'd0, 1'b0),
            row(KIND_SEED, 64'(MULT_DEFAULT), 32'd0, 1'b0, 64'd0, 1'b0),
            row(KIND_FLOAT, 64'd0, 32'd0, 1'b1, 64'd0, 1'b0),
            row(KIND_SEED, 64'(MULT_DEFAULT), 32'd0, 1'b0, 64'd0, 1'b0),
            row(KIND_INT32, 64'd0, 32'd0, 1'b1, 64'd0, 1'b0),
            row(KIND_BOUNDED, 64'd0, 32'd1, 1'b1, 64'd0, 1'b0),
            row(KIND_BOUNDED, 64'd0, 32'd2, 1'b0, 64'd0, 1'b0),
            row(KIND_BOUNDED, 64'd0, 32'h4000_0000, 1'b0, 64'd0, 1'b0),
            row(KIND_BOUNDED, 64'd0, 32'h7FFF_FFFF, 1'b0, 64'd0, 1'b0),
            row(KIND_BOUNDED, 64'd0, 32'd3, 1'b0, 64'd0, 1'b0),
            row(KIND_BOUNDED, 64'd0, 32'h4000_0001, 1'b0, 64'd0, 1'b0),
            row(KIND_SEED, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b0, 64'd0, 1'b0),
            row(KIND_INT64, 64'd0, 32'd0, 1'b0, 64'd0, 1'b0),
            row(KIND_DOUBLE, 64'd0, 32'd0, 1'b0, 64'd0, 1'b0),
            row(KIND_SEED, 64'h8000_0000_0000_0000, 32'd0, 1'b0, 64'd0, 1'b0),
            row(KIND_INT32, 64'd0, 32'd0, 1'b0, 64'd0, 1'b0),
            row(KIND_FLOAT, 64'd0, 32'd0, 1'b0, 64'd0, 1'b0),
            row(KIND_BOOL, 64'd0, 32'd0, 1'b0, 64'd0, 1'b0),
            row(KIND_INT64, 64'd0, 32'd0, 1'b0, 64'd0, 1'b0)
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_rate = 10;
        stall_rate = 10;
        foreach (dir_rows[i])
            send_req(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].want);

        for (int p = 0; p < N_PHASES; p++)
        begin
            drain();
            write_mult(ph_mult[p]);
            if (p == N_PHASES - 1)
            begin
                gap_rate = 0;
                stall_rate = 0;
            end
            else
            begin
                gap_rate = $urandom_range(3, 0) * 5;
                stall_rate = $urandom_range(3, 0) * 5;
            end
            // multiplier of one barely moves the top bits: this redraw runs to the try limit
            if (ph_mult[p] == 48'd1)
            begin
                r.kind = KIND_SEED;
                r.seed_value = 64'h0000_FFFF_0000_0000;
                r.bound = 32'd0;
                send_req(r, 1'b0, none);
                r.kind = KIND_BOUNDED;
                r.bound = 32'h4000_0001;
                send_req(r, 1'b0, none);
            end
            sent = 0;
            while (sent < ph_items[p])
            begin
                r = pick_req(ph_tame[p]);
                send_req(r, 1'b0, none);
                if (r.kind != KIND_UNUSED)
                    sent++;
            end
        end

        drain();
        if (pending_draws.size() != 0)
            mismatches++;
        $display("tb_top: %0d requests over %0d multiplier settings, %0d responses checked",
                 n_sent, N_PHASES, n_checked);
        $display("tb_top: %0d bad-bound responses, random idling on both channels",
                 n_bad_bound);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

[sim.f]
rtl/lcg48_pkg.sv
rtl/lcg48_random_generator_core.sv
rtl/lcg48_checker.sv
dv/tb_top.sv
